// ===== hw/rtl/astar_pkg.sv =====
package astar_pkg;

  // Graph and score dimensions.
  localparam int unsigned NODES    = 64;
  localparam int unsigned NODE_W   = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned MAX_DEG  = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned DEG_W    = 4;
  localparam int unsigned EDGE_AW  = NODE_W + SLOT_W;
  localparam int unsigned SCORE_W  = 24;
  localparam int unsigned COST_W   = 16;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned KEY_W    = SCORE_W + NODE_W;
  localparam int unsigned ROOT_W   = 17;
  localparam int unsigned RAD_W    = 34;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_RESET = CNT_W'(NODES);

  // Command codes.
  localparam logic [1:0] CMD_NODE   = 2'd0;
  localparam logic [1:0] CMD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_PATH   = 2'd0;
  localparam logic [1:0] ST_NOPATH = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;
  localparam logic [1:0] ST_DEGOVF = 2'd3;

  typedef struct packed {
    logic [1:0]                command;
    logic [NODE_W-1:0]         node_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [NODE_W-1:0]         edge_target;
    logic [COST_W-1:0]         edge_cost;
    logic [NODE_W-1:0]         start_node;
    logic [NODE_W-1:0]         goal_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_node;
    logic              last;
    logic [1:0]        status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EDGE_APP, S_ERR, S_INIT, S_GOAL, S_POP, S_SCAN, S_POPWR,
    S_EXP_LAT, S_EDGE_RD, S_EDGE_LAT, S_NB_CMP, S_MULX, S_MULY, S_ADD,
    S_SQRT, S_PUSH, S_TRST, S_TR, S_TRWR, S_EMRD, S_EMWR
  } state_e;

endpackage

// ===== hw/rtl/astar_graph_path_search_top.sv =====
// A* path search over a loaded graph of up to 64 nodes.
// Input channel (in_valid_i / in_stall_o, payload in_data_i) takes one command per
// transfer: load node coordinates, append an edge, or run a search. Output channel
// (out_valid_o / out_stall_i, payload out_data_o) returns results: the path nodes,
// start first, with last set on the final one, or one flagged result on a bad
// index, degree overflow or missing path. cfg_we_i / cfg_wdata_i set node_count.
// A node load completes in the idle state; an edge append adds an update state and,
// on overflow, a state to emit a flag. A search is run by one sequencer over memories
// with registered reads: each pop scans the open queue at one entry per cycle, then
// moves the last entry into the popped slot, and a newly queued node uses the shared
// 16x16 multiplier and the 17-step square root. The path is then traced back from the
// goal into a buffer and emitted from it. The input is stalled until a command is
// fully done.
// Reset clears the control state, the degree counts and sets node_count to 64;
// node positions and edges are undefined until loaded. A stalled output holds its
// result in the output register and the sequencer waits until it is taken.
module astar_graph_path_search_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  astar_pkg::in_item_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output astar_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i
);
  import astar_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0] ncount_q;
  logic [CNT_W-1:0] cnt;
  in_item_t         req_q, req_d;
  logic [1:0]       rstat_q, rstat_d;

  // Memories and their ports.
  logic [2*COORD_W-1:0]      node_mem [NODES];
  logic [DEG_W-1:0]          deg_mem [NODES];
  logic [NODE_W+COST_W-1:0]  edge_mem [NODES*MAX_DEG];
  logic [SCORE_W-1:0]        best_mem [NODES];
  logic [NODE_W-1:0]         par_mem [NODES];
  logic [KEY_W-1:0]          heap_mem [NODES];
  logic [NODE_W-1:0]         path_mem [NODES];

  logic                      node_we;
  logic [NODE_W-1:0]         node_wa, node_ra;
  logic [2*COORD_W-1:0]      node_rd_q;
  logic                      deg_we;
  logic [NODE_W-1:0]         deg_wa, deg_ra;
  logic [DEG_W-1:0]          deg_wd, deg_rd_q;
  logic                      deg_rv_q;
  logic [NODES-1:0]          deg_vld_q, deg_vld_d;
  logic                      edge_we;
  logic [EDGE_AW-1:0]        edge_wa, edge_ra;
  logic [NODE_W+COST_W-1:0]  edge_rd_q;
  logic                      best_we;
  logic [NODE_W-1:0]         best_wa, best_ra;
  logic [SCORE_W-1:0]        best_wd, best_rd_q;
  logic                      best_rv_q;
  logic [NODES-1:0]          bs_vld_q, bs_vld_d;
  logic [NODES-1:0]          ever_q, ever_d;
  logic                      par_we;
  logic [NODE_W-1:0]         par_wa, par_ra, par_rd_q;
  logic                      heap_we;
  logic [NODE_W-1:0]         heap_wa, heap_ra;
  logic [KEY_W-1:0]          heap_wd, heap_rd_q;
  logic                      path_we;
  logic [NODE_W-1:0]         path_wa, path_ra, path_wd, path_rd_q;

  // Search registers.
  logic [CNT_W-1:0]          hsize_q, hsize_d;
  logic [CNT_W-1:0]          scan_q, scan_d;
  logic                      pend_q, pend_d;
  logic [NODE_W-1:0]         pidx_q, pidx_d;
  logic [KEY_W-1:0]          bkey_q, bkey_d;
  logic [NODE_W-1:0]         bidx_q, bidx_d;
  logic [NODE_W-1:0]         cur_q, cur_d;
  logic [DEG_W-1:0]          dcur_q, dcur_d;
  logic [SCORE_W-1:0]        gcur_q, gcur_d;
  logic [DEG_W-1:0]          ei_q, ei_d;
  logic [NODE_W-1:0]         nb_q, nb_d;
  logic [SCORE_W-1:0]        g_q, g_d;
  logic [COORD_W-1:0]        gx_q, gx_d, gy_q, gy_d;
  logic [COORD_W-1:0]        nx_q, nx_d, ny_q, ny_d;
  logic [2*COORD_W-1:0]      p_q, p_d;
  logic [RAD_W-1:0]          v_q, v_d, root_q, root_d, bit_q, bit_d;
  logic [CNT_W-1:0]          plen_q, plen_d;
  logic [CNT_W-1:0]          steps_q, steps_d;
  logic [NODE_W-1:0]         tcur_q, tcur_d;

  // Output register.
  logic      out_vld_q;
  out_item_t out_q;
  logic      out_free, out_load;
  out_item_t out_d;

  // Combinational helpers.
  logic                 in_xfer;
  logic [SCORE_W:0]     gsum, fsum;
  logic [SCORE_W-1:0]   gsat, fsat, bs_nb;
  logic [COORD_W:0]     ddx, ddy;
  logic [COORD_W-1:0]   adx, ady, mul_a;
  logic [RAD_W-1:0]     trial;
  logic [DEG_W-1:0]     deg_cur;
  logic [NODE_W-1:0]    edge_nb;
  logic [COST_W-1:0]    edge_w;
  logic [NODE_W-1:0]    bid;

  assign cnt      = (ncount_q > CNT_W'(NODES)) ? CNT_W'(NODES) : ncount_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign deg_cur = deg_rv_q ? deg_rd_q : '0;
  assign edge_nb = edge_rd_q[NODE_W+COST_W-1:COST_W];
  assign edge_w  = edge_rd_q[COST_W-1:0];
  assign bid     = bkey_q[NODE_W-1:0];

  // Saturating score sums.
  assign gsum = {1'b0, gcur_q} + {{(SCORE_W+1-COST_W){1'b0}}, edge_w};
  assign gsat = gsum[SCORE_W] ? SCORE_MAX : gsum[SCORE_W-1:0];
  assign fsum = {1'b0, g_q} + {{(SCORE_W+1-ROOT_W){1'b0}}, root_q[ROOT_W-1:0]};
  assign fsat = fsum[SCORE_W] ? SCORE_MAX : fsum[SCORE_W-1:0];
  assign bs_nb = best_rv_q ? best_rd_q : SCORE_MAX;

  // Absolute coordinate differences feeding the shared multiplier.
  assign ddx   = {nx_q[COORD_W-1], nx_q} - {gx_q[COORD_W-1], gx_q};
  assign ddy   = {ny_q[COORD_W-1], ny_q} - {gy_q[COORD_W-1], gy_q};
  assign adx   = ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
  assign ady   = ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
  assign mul_a = (state_q == S_MULX) ? adx : ady;
  assign trial = root_q + bit_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data_i.command)
            CMD_NODE: begin
              if ({1'b0, in_data_i.node_index} >= cnt) state_d = S_ERR;
            end
            CMD_EDGE: begin
              if ({1'b0, in_data_i.node_index} >= cnt ||
                  {1'b0, in_data_i.edge_target} >= cnt) state_d = S_ERR;
              else state_d = S_EDGE_APP;
            end
            CMD_SEARCH: begin
              if ({1'b0, in_data_i.start_node} >= cnt ||
                  {1'b0, in_data_i.goal_node} >= cnt) state_d = S_ERR;
              else state_d = S_INIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_EDGE_APP: state_d = (deg_cur >= DEG_W'(MAX_DEG)) ? S_ERR : S_IDLE;
      S_ERR:      if (out_free) state_d = S_IDLE;
      S_INIT:     state_d = S_GOAL;
      S_GOAL:     state_d = S_POP;
      S_POP:      state_d = (hsize_q == '0) ? S_ERR : S_SCAN;
      S_SCAN:     if (scan_q == hsize_q && !pend_q) state_d = S_POPWR;
      S_POPWR: begin
        if ({1'b0, bid} >= cnt) state_d = S_POP;
        else if (bid == req_q.goal_node) state_d = S_TRST;
        else state_d = S_EXP_LAT;
      end
      S_EXP_LAT:  state_d = S_EDGE_RD;
      S_EDGE_RD:  state_d = (ei_q >= dcur_q) ? S_POP : S_EDGE_LAT;
      S_EDGE_LAT: state_d = ({1'b0, edge_nb} >= cnt) ? S_EDGE_RD : S_NB_CMP;
      S_NB_CMP: begin
        if (g_q < bs_nb && !ever_q[nb_q]) state_d = S_MULX;
        else state_d = S_EDGE_RD;
      end
      S_MULX:     state_d = S_MULY;
      S_MULY:     state_d = S_ADD;
      S_ADD:      state_d = S_SQRT;
      S_SQRT:     if (bit_q[0]) state_d = S_PUSH;
      S_PUSH:     state_d = S_EDGE_RD;
      S_TRST:     state_d = S_TR;
      S_TR: begin
        if (tcur_q != req_q.start_node && steps_q < cnt && plen_q < CNT_W'(NODES))
          state_d = S_TRWR;
        else state_d = S_EMRD;
      end
      S_TRWR:     state_d = S_TR;
      S_EMRD:     state_d = S_EMWR;
      S_EMWR: begin
        if (out_free) state_d = (plen_q == CNT_W'(1)) ? S_IDLE : S_EMRD;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    req_d = req_q;     rstat_d = rstat_q;
    deg_vld_d = deg_vld_q; bs_vld_d = bs_vld_q; ever_d = ever_q;
    hsize_d = hsize_q; scan_d = scan_q; pend_d = pend_q; pidx_d = pidx_q;
    bkey_d = bkey_q;   bidx_d = bidx_q; cur_d = cur_q;
    dcur_d = dcur_q;   gcur_d = gcur_q; ei_d = ei_q; nb_d = nb_q; g_d = g_q;
    gx_d = gx_q; gy_d = gy_q; nx_d = nx_q; ny_d = ny_q;
    p_d = p_q; v_d = v_q; root_d = root_q; bit_d = bit_q;
    plen_d = plen_q; steps_d = steps_q; tcur_d = tcur_q;
    node_we = 1'b0; node_wa = in_data_i.node_index; node_ra = nb_q;
    deg_we = 1'b0;  deg_wa = req_q.node_index; deg_wd = '0; deg_ra = cur_q;
    edge_we = 1'b0; edge_wa = {req_q.node_index, deg_cur[SLOT_W-1:0]};
    edge_ra = {cur_q, ei_q[SLOT_W-1:0]};
    best_we = 1'b0; best_wa = nb_q; best_wd = g_q; best_ra = cur_q;
    par_we = 1'b0;  par_wa = nb_q; par_ra = tcur_q;
    heap_we = 1'b0; heap_wa = hsize_q[NODE_W-1:0]; heap_wd = {fsat, nb_q};
    heap_ra = scan_q[NODE_W-1:0];
    path_we = 1'b0; path_wa = plen_q[NODE_W-1:0]; path_wd = par_rd_q;
    path_ra = NODE_W'(plen_q - CNT_W'(1));
    out_load = 1'b0;
    out_d = '{path_node: path_rd_q, last: (plen_q == CNT_W'(1)), status: ST_PATH};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d = in_data_i;
          rstat_d = ST_BADIDX;
          deg_wa = in_data_i.node_index;
          deg_ra = in_data_i.node_index;
          if (in_data_i.command == CMD_NODE && {1'b0, in_data_i.node_index} < cnt) begin
            node_we = 1'b1;
            deg_we = 1'b1;
            deg_vld_d[in_data_i.node_index] = 1'b1;
          end
        end
      end
      S_EDGE_APP: begin
        rstat_d = ST_DEGOVF;
        if (deg_cur < DEG_W'(MAX_DEG)) begin
          edge_we = 1'b1;
          deg_we = 1'b1;
          deg_wd = deg_cur + DEG_W'(1);
          deg_vld_d[req_q.node_index] = 1'b1;
        end
      end
      S_ERR: begin
        out_d = '{path_node: '0, last: 1'b1, status: rstat_q};
        out_load = out_free;
      end
      S_INIT: begin
        bs_vld_d = '0;
        bs_vld_d[req_q.start_node] = 1'b1;
        ever_d = '0;
        best_we = 1'b1;
        best_wa = req_q.start_node;
        best_wd = '0;
        heap_we = 1'b1;
        heap_wa = '0;
        heap_wd = {{SCORE_W{1'b0}}, req_q.start_node};
        hsize_d = CNT_W'(1);
        node_ra = req_q.goal_node;
      end
      S_GOAL: begin
        gx_d = node_rd_q[2*COORD_W-1:COORD_W];
        gy_d = node_rd_q[COORD_W-1:0];
      end
      S_POP: begin
        rstat_d = ST_NOPATH;
        scan_d = '0;
        pend_d = 1'b0;
      end
      // Linear scan for the smallest queue key, one entry per cycle.
      S_SCAN: begin
        if (scan_q < hsize_q) begin
          heap_ra = scan_q[NODE_W-1:0];
          scan_d = scan_q + CNT_W'(1);
          pend_d = 1'b1;
          pidx_d = scan_q[NODE_W-1:0];
        end else begin
          heap_ra = NODE_W'(hsize_q - CNT_W'(1));
          pend_d = 1'b0;
        end
        if (pend_q && (pidx_q == '0 || heap_rd_q < bkey_q)) begin
          bkey_d = heap_rd_q;
          bidx_d = pidx_q;
        end
      end
      // Move the last entry into the popped slot and fetch the node's data.
      S_POPWR: begin
        heap_we = 1'b1;
        heap_wa = bidx_q;
        heap_wd = heap_rd_q;
        hsize_d = hsize_q - CNT_W'(1);
        cur_d = bid;
        deg_ra = bid;
        best_ra = bid;
      end
      S_EXP_LAT: begin
        dcur_d = deg_cur;
        gcur_d = best_rv_q ? best_rd_q : SCORE_MAX;
        ei_d = '0;
      end
      S_EDGE_LAT: begin
        nb_d = edge_nb;
        g_d = gsat;
        best_ra = edge_nb;
        node_ra = edge_nb;
        if ({1'b0, edge_nb} >= cnt) ei_d = ei_q + DEG_W'(1);
      end
      // Relax the edge to the neighbor.
      S_NB_CMP: begin
        nx_d = node_rd_q[2*COORD_W-1:COORD_W];
        ny_d = node_rd_q[COORD_W-1:0];
        if (g_q < bs_nb) begin
          par_we = 1'b1;
          best_we = 1'b1;
          bs_vld_d[nb_q] = 1'b1;
          if (!ever_q[nb_q]) ever_d[nb_q] = 1'b1;
          else ei_d = ei_q + DEG_W'(1);
        end else begin
          ei_d = ei_q + DEG_W'(1);
        end
      end
      S_MULX: p_d = mul_a * mul_a;
      S_MULY: begin
        p_d = mul_a * mul_a;
        v_d = RAD_W'(p_q);
      end
      S_ADD: begin
        v_d = v_q + RAD_W'(p_q);
        root_d = '0;
        bit_d = RAD_W'(1) << (RAD_W - 2);
      end
      // One result bit of the integer square root per cycle.
      S_SQRT: begin
        if (v_q >= trial) begin
          v_d = v_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      S_PUSH: begin
        if (hsize_q < CNT_W'(NODES)) begin
          heap_we = 1'b1;
          hsize_d = hsize_q + CNT_W'(1);
        end
        ei_d = ei_q + DEG_W'(1);
      end
      // Trace parents back from the goal into the path buffer.
      S_TRST: begin
        path_we = 1'b1;
        path_wa = '0;
        path_wd = cur_q;
        plen_d = CNT_W'(1);
        steps_d = '0;
        tcur_d = cur_q;
      end
      S_TRWR: begin
        path_we = 1'b1;
        tcur_d = par_rd_q;
        plen_d = plen_q + CNT_W'(1);
        steps_d = steps_q + CNT_W'(1);
      end
      S_EMWR: begin
        out_load = out_free;
        if (out_free) plen_d = plen_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ncount_q  <= CNT_RESET;
      deg_vld_q <= '0;
      bs_vld_q  <= '0;
      ever_q    <= '0;
      hsize_q   <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) ncount_q <= cfg_wdata_i;
      deg_vld_q <= deg_vld_d;
      bs_vld_q  <= bs_vld_d;
      ever_q    <= ever_d;
      hsize_q   <= hsize_d;
      pend_q    <= pend_d;
      if (out_load) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;   rstat_q <= rstat_d;
    scan_q <= scan_d; pidx_q <= pidx_d; bkey_q <= bkey_d; bidx_q <= bidx_d;
    cur_q <= cur_d;   dcur_q <= dcur_d; gcur_q <= gcur_d; ei_q <= ei_d;
    nb_q <= nb_d;     g_q <= g_d;
    gx_q <= gx_d; gy_q <= gy_d; nx_q <= nx_d; ny_q <= ny_d;
    p_q <= p_d; v_q <= v_d; root_q <= root_d; bit_q <= bit_d;
    plen_q <= plen_d; steps_q <= steps_d; tcur_q <= tcur_d;
    if (out_load) out_q <= out_d;
  end

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa] <= {in_data_i.coord_x, in_data_i.coord_y};
    node_rd_q <= node_mem[node_ra];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd_q <= deg_mem[deg_ra];
    deg_rv_q <= deg_vld_q[deg_ra];
    if (edge_we) edge_mem[edge_wa] <= {req_q.edge_target, req_q.edge_cost};
    edge_rd_q <= edge_mem[edge_ra];
    if (best_we) best_mem[best_wa] <= best_wd;
    best_rd_q <= best_mem[best_ra];
    best_rv_q <= bs_vld_q[best_ra];
    if (par_we) par_mem[par_wa] <= cur_q;
    par_rd_q <= par_mem[par_ra];
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd_q <= heap_mem[heap_ra];
    if (path_we) path_mem[path_wa] <= path_wd;
    path_rd_q <= path_mem[path_ra];
  end

endmodule
